### rtl/core/multicast_group_membership_table_defines.svh
// Assertion helpers shared by the table RTL.
`ifndef MULTICAST_GROUP_MEMBERSHIP_TABLE_DEFINES_SVH
`define MULTICAST_GROUP_MEMBERSHIP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MGMT_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mgmt: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MGMT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mgmt: next-cycle check failed");

`endif

### rtl/core/mgmt_pkg.sv
`timescale 1ns / 1ps

package mgmt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBSCRIPTION_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE_MASK     = 2'd1;

  localparam logic [31:0] TIMEOUT_RESET   = 32'd300;
  localparam logic [7:0]  PORT_MASK_RESET = 8'hFF;

  typedef struct packed {
    logic [63:0] group_addr_high;
    logic [63:0] group_addr_low;
    logic [2:0]  ingress_port;
    logic [31:0] now_seconds;
  } req_beat_t;

  typedef struct packed {
    logic [7:0] report_mask;
    logic [5:0] entry_index;
    logic       group_was_new;
    logic       member_was_new;
    logic       table_full;
  } rsp_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESOLVE
  } mgmt_state_t;

endpackage

### rtl/core/mgmt_cell.sv
`timescale 1ns / 1ps

module mgmt_cell import mgmt_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W = 6,
  parameter type status_t = logic,
  parameter type write_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] query_high,
  input  logic [63:0] query_low,
  input  status_t     stat_in,
  output status_t     stat_out,
  input  write_t      wr
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [31:0] last_fwd;
  logic [$bits(wr.members)-1:0] members;

  logic    match;
  logic    wr_hit;
  status_t stat_next;

  assign match  = valid && (addr_high == query_high) && (addr_low == query_low);
  assign wr_hit = wr.en && (wr.slot == MY_IDX);

  // first valid match wins; otherwise remember the first free slot
  always_comb begin
    stat_next = stat_in;
    if (!stat_in.hit && match) begin
      stat_next.hit      = 1'b1;
      stat_next.slot     = MY_IDX;
      stat_next.last_fwd = last_fwd;
      stat_next.members  = members;
    end else if (!stat_in.hit && !stat_in.free_found && !valid) begin
      stat_next.free_found = 1'b1;
      stat_next.slot       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_out <= '0;
    end else begin
      stat_out <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_hit && wr.alloc) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      if (wr.alloc) begin
        addr_high <= query_high;
        addr_low  <= query_low;
      end
      if (wr.set_fwd) begin
        last_fwd <= wr.now;
      end
      members <= wr.members;
    end
  end

endmodule

### rtl/core/multicast_group_membership_table.sv
// A taken request beat sets start_pulse, which sends the search token into the cell chain.
// The token walks the chain one cell per cycle and is captured into fin at the chain end;
//   resolve then writes back to the owning cell and registers the response beat once the
//   previous beat is taken, and the next request beat is taken in the cycle after that.
// A new request is taken while the previous response beat still waits in its register.
// Reset (synchronous, rst high): all entries invalid, timeout 300 s, all ports enabled.
`timescale 1ns / 1ps

`include "multicast_group_membership_table_defines.svh"

module multicast_group_membership_table import mgmt_pkg::*; #(
  parameter int GROUP_ENTRIES = 64,
  parameter int PORT_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // join requests
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_beat_t             req,
  // responses
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_beat_t             rsp
);

  localparam int IDX_W = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;

  // Search token handed from cell to cell. Once a hit is seen it carries the
  // matching entry's timestamp and membership; before that it may carry the
  // lowest free slot.
  typedef struct packed {
    logic                  active;
    logic                  hit;
    logic                  free_found;
    logic [IDX_W-1:0]      slot;
    logic [31:0]           last_fwd;
    logic [PORT_COUNT-1:0] members;
  } status_t;

  // Write-back broadcast; only the cell whose index equals slot takes it.
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      slot;
    logic                  alloc;
    logic                  set_fwd;
    logic [31:0]           now;
    logic [PORT_COUNT-1:0] members;
  } write_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] timeout;
  logic [7:0]  port_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= TIMEOUT_RESET;
      port_mask <= PORT_MASK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SUBSCRIPTION_TIMEOUT: timeout   <= cfg_data;
        CFG_PORT_ENABLE_MASK:     port_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  mgmt_state_t state, state_next;
  logic        req_take;
  logic        out_free;
  logic        capture;
  logic        commit;
  logic        start_pulse;
  req_beat_t   query;
  status_t     chain_head;
  status_t     chain [GROUP_ENTRIES];
  status_t     chain_end;
  status_t     fin;
  write_t      wr;

  assign chain_end = chain[GROUP_ENTRIES-1];
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (req_valid) state_next = ST_SEARCH;
      ST_SEARCH:  if (chain_end.active) state_next = ST_RESOLVE;
      ST_RESOLVE: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    capture   = 1'b0;
    commit    = 1'b0;
    case (state)
      ST_IDLE:    req_ready = 1'b1;
      ST_SEARCH:  capture   = chain_end.active;
      ST_RESOLVE: commit    = out_free;
      default: ;
    endcase
  end

  assign req_take = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_pulse <= 1'b0;
    end else begin
      state       <= state_next;
      start_pulse <= req_take;
    end
  end

  // query held steady for the whole walk and write-back
  always_ff @(posedge clk) begin
    if (req_take) begin
      query <= req;
    end
    if (capture) begin
      fin <= chain_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  always_comb begin
    chain_head        = '0;
    chain_head.active = start_pulse;
  end

  for (genvar i = 0; i < GROUP_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      mgmt_cell #(
        .CELL_IDX (i),
        .IDX_W    (IDX_W),
        .status_t (status_t),
        .write_t  (write_t)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .query_high (query.group_addr_high),
        .query_low  (query.group_addr_low),
        .stat_in    (chain_head),
        .stat_out   (chain[i]),
        .wr         (wr)
      );
    end else begin : g_next
      mgmt_cell #(
        .CELL_IDX (i),
        .IDX_W    (IDX_W),
        .status_t (status_t),
        .write_t  (write_t)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .query_high (query.group_addr_high),
        .query_low  (query.group_addr_low),
        .stat_in    (chain[i-1]),
        .stat_out   (chain[i]),
        .wr         (wr)
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Resolve: timeout check, report mask, membership update
  // ---------------------------------------------------------------------------
  logic                  full;
  logic                  forward;
  logic                  member_new;
  logic [31:0]           elapsed;
  logic [31:0]           slot_ext;
  logic [PORT_COUNT-1:0] port_bit;
  logic [PORT_COUNT-1:0] members_old;
  logic [7:0]            report_all;
  rsp_beat_t             rsp_next;

  always_comb begin
    // ingress at or beyond PORT_COUNT sets no bit and excludes nobody
    for (int p = 0; p < PORT_COUNT; p++) begin
      port_bit[p] = (int'(query.ingress_port) == p);
    end
    for (int b = 0; b < 8; b++) begin
      report_all[b] = port_mask[b] && (b < PORT_COUNT) && (int'(query.ingress_port) != b);
    end

    full        = !fin.hit && !fin.free_found;
    elapsed     = query.now_seconds - fin.last_fwd;
    forward     = !fin.hit || (elapsed >= timeout);
    members_old = fin.hit ? fin.members : '0;
    member_new  = (|port_bit) && !(|(members_old & port_bit));
    slot_ext    = 32'(fin.slot);

    wr         = '0;
    wr.en      = commit && !full;
    wr.slot    = fin.slot;
    wr.alloc   = !fin.hit;
    wr.set_fwd = forward;
    wr.now     = query.now_seconds;
    wr.members = members_old | port_bit;

    rsp_next = '0;
    if (full) begin
      rsp_next.table_full = 1'b1;
    end else begin
      rsp_next.report_mask    = forward ? report_all : 8'h00;
      rsp_next.entry_index    = slot_ext[5:0];
      rsp_next.group_was_new  = !fin.hit;
      rsp_next.member_was_new = member_new;
    end
  end

  // response register: one beat waits here while the next join walks
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MGMT_ASSERT_IMPL(a_token_in_search, clk, rst, chain_end.active, state == ST_SEARCH)
  `MGMT_ASSERT_NEXT(a_commit_shows_beat, clk, rst, commit, rsp_valid)
  `MGMT_ASSERT_IMPL(a_full_beat_clean, clk, rst, rsp_valid && rsp.table_full,
                    rsp.report_mask == 8'h00 && !rsp.group_was_new && !rsp.member_was_new
                    && rsp.entry_index == 6'd0)
  `MGMT_ASSERT_IMPL(a_no_write_when_full, clk, rst, wr.en, !full && state == ST_RESOLVE)

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mgmt_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam int POOL_GROUPS = 36;
  // Indexes that decode to no register: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_beat_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_beat_t rsp;

  multicast_group_membership_table dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the group table and the two registers.
  logic        grp_valid [TABLE_SLOTS];
  logic [63:0] grp_high [TABLE_SLOTS];
  logic [63:0] grp_low [TABLE_SLOTS];
  logic [31:0] grp_last_fwd [TABLE_SLOTS];
  logic [7:0]  grp_members [TABLE_SLOTS];
  logic [31:0] timeout_secs = TIMEOUT_RESET;
  logic [7:0]  enabled_ports = PORT_MASK_RESET;

  rsp_beat_t expected_replies[$];
  logic [127:0] group_pool [POOL_GROUPS];

  int mismatches = 0;
  int joins_sent = 0;
  int replies_seen = 0;
  int groups_in_use = 0;
  int forwards = 0;
  int full_replies = 0;
  int new_members = 0;
  int reg_writes = 0;

  // Stimulus shaping: calm_tx / calm_rx switch off random idling on one side;
  // holdoff_req asks the receiver to hold rsp_ready low for that many cycles.
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;
  int holdoff_req = 0;
  int holdoff_left = 0;

  initial for (int i = 0; i < TABLE_SLOTS; i++) grp_valid[i] = 1'b0;

  function automatic int find_group(input logic [63:0] hi, input logic [63:0] lo);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (grp_valid[i] && grp_high[i] == hi && grp_low[i] == lo) return i;
    return -1;
  endfunction

  // Expected reply for one join; updates the shadow table as the block would.
  function automatic rsp_beat_t predict_join(input req_beat_t j);
    rsp_beat_t r;
    int slot;
    logic [7:0] port_bit;
    logic [31:0] age;
    logic fwd;
    r = '0;
    fwd = 1'b0;
    port_bit = 8'b1 << j.ingress_port;
    slot = find_group(j.group_addr_high, j.group_addr_low);
    if (slot < 0) begin
      // miss: take the lowest free slot, or report a full table
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (!grp_valid[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        r.table_full = 1'b1;
        full_replies++;
        return r;
      end
      grp_valid[slot] = 1'b1;
      grp_high[slot] = j.group_addr_high;
      grp_low[slot] = j.group_addr_low;
      grp_members[slot] = '0;
      r.group_was_new = 1'b1;
      groups_in_use++;
      fwd = 1'b1;
    end else begin
      age = j.now_seconds - grp_last_fwd[slot];
      fwd = (age >= timeout_secs);
    end
    if (fwd) begin
      r.report_mask = enabled_ports & ~port_bit;
      grp_last_fwd[slot] = j.now_seconds;
      forwards++;
    end
    if ((grp_members[slot] & port_bit) == 8'h00) begin
      grp_members[slot] = grp_members[slot] | port_bit;
      r.member_was_new = 1'b1;
      new_members++;
    end
    r.entry_index = slot[5:0];
    return r;
  endfunction

  function automatic req_beat_t join_of(input logic [127:0] grp, input int port,
                                        input logic [31:0] now);
    req_beat_t j;
    j.group_addr_high = grp[127:64];
    j.group_addr_low = grp[63:0];
    j.ingress_port = port[2:0];
    j.now_seconds = now;
    return j;
  endfunction

  function automatic logic [127:0] fresh_group();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random join; for a known group the time mostly lands near the forward
  // boundary or a little after the last forward.
  function automatic req_beat_t random_join(input logic [127:0] grp);
    int slot;
    logic [31:0] now;
    logic [31:0] last;
    slot = find_group(grp[127:64], grp[63:0]);
    now = $urandom;
    if (slot >= 0) begin
      last = grp_last_fwd[slot];
      case ($urandom_range(3))
        0: now = last + timeout_secs + $urandom_range(2) - 1;
        1: now = last + $urandom_range(600);
        2: now = last + timeout_secs + $urandom_range(4000);
        default: ;
      endcase
    end
    return join_of(grp, $urandom_range(7), now);
  endfunction

  // One join beat; valid stays high on return so a back-to-back beat can follow.
  task automatic send_join(input req_beat_t item);
    int gap;
    gap = 0;
    if (!calm_tx) while ($urandom_range(99) < 12) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_replies.push_back(predict_join(item));
    joins_sent++;
  endtask

  // Drop valid and wait until every reply is in; the block is then idle.
  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SUBSCRIPTION_TIMEOUT) timeout_secs = val;
    else if (idx == CFG_PORT_ENABLE_MASK) enabled_ports = val[7:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Receiver: ~12% random stalls, none while calm, and a counted hold-off on request.
  always @(posedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm_rx || ($urandom_range(99) >= 12);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Reply checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("reply beat with no join outstanding: %p", rsp);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        check_field("report_mask", 64'(want.report_mask), 64'(rsp.report_mask));
        check_field("entry_index", 64'(want.entry_index), 64'(rsp.entry_index));
        check_field("group_was_new", 64'(want.group_was_new), 64'(rsp.group_was_new));
        check_field("member_was_new", 64'(want.member_was_new), 64'(rsp.member_was_new));
        check_field("table_full", 64'(want.table_full), 64'(rsp.table_full));
      end
    end
  end

  // Extreme addresses, forward boundary at the reset timeout, time wrap.
  task automatic test_directed_joins();
    logic [127:0] g0;
    logic [127:0] g1;
    g0 = '0;
    g1 = '1;
    send_join(join_of(g0, 0, 32'd0));          // new group, slot 0
    send_join(join_of(g0, 0, 32'd299));        // one second short of timeout
    send_join(join_of(g0, 7, 32'd300));        // exactly at timeout
    send_join(join_of(g1, 7, 32'hFFFF_FFFF));  // new group, slot 1
    send_join(join_of(g1, 3, 32'd299));        // 300 s later across the wrap
    send_join(join_of({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 5, 32'd1000));
    send_join(join_of({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 2, 32'd1000));
    send_join(join_of(g0, 1, 32'd599));        // within timeout of last forward
    send_join(join_of(g1, 3, 32'd300));        // same port again: not a new member
  endtask

  // Port mask and timeout extremes, disabled ingress port, spare indexes.
  task automatic test_register_settings();
    logic [127:0] g2;
    g2 = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    wait_idle();
    write_reg(CFG_PORT_ENABLE_MASK, 32'h0);
    send_join(join_of(fresh_group(), 4, 32'd5000));   // new group, nobody to tell
    wait_idle();
    write_reg(CFG_PORT_ENABLE_MASK, 32'h5A);
    send_join(join_of(g2, 1, 32'd100000));            // ingress enabled in the mask, left out of its own report
    wait_idle();
    write_reg(CFG_SUBSCRIPTION_TIMEOUT, 32'h0);
    send_join(join_of(g2, 3, 32'd100000));            // zero timeout: always forwarded
    wait_idle();
    write_reg(CFG_SUBSCRIPTION_TIMEOUT, 32'hFFFF_FFFF);
    send_join(join_of(g2, 4, 32'd99999));             // age wraps to the maximum
    send_join(join_of(g2, 4, 32'd99999));             // age zero
    wait_idle();
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    send_join(join_of(g2, 6, 32'd5));                 // large age, still short
    wait_idle();
    write_reg(CFG_SUBSCRIPTION_TIMEOUT, TIMEOUT_RESET);
    write_reg(CFG_PORT_ENABLE_MASK, {24'h0, PORT_MASK_RESET});
  endtask

  // Phases of random joins, each under its own register setting. The pool
  // holds random groups plus near misses a single address bit away.
  task automatic test_random_joins();
    logic [31:0] phase_timeout [7];
    logic [7:0]  phase_ports [7];
    logic [127:0] grp;
    phase_timeout = '{32'd300, 32'd0, 32'd1, 32'hFFFF_FFFF, $urandom, 32'd45, 32'd300};
    phase_ports = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'($urandom), 8'h81, 8'hFF};
    for (int i = 0; i < POOL_GROUPS; i++)
      if (i >= 4 && $urandom_range(9) < 4)
        group_pool[i] = group_pool[$urandom_range(i - 1)] ^ (128'b1 << $urandom_range(127));
      else
        group_pool[i] = fresh_group();
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(CFG_SUBSCRIPTION_TIMEOUT, phase_timeout[p]);
      // upper data bits are don't-care for the port mask
      write_reg(CFG_PORT_ENABLE_MASK, {24'($urandom_range(24'hFF_FFFF)), phase_ports[p]});
      calm_tx = (p == 2);
      calm_rx = (p == 2);
      repeat (150) begin
        if ($urandom_range(99) < 2) grp = fresh_group();
        else grp = group_pool[$urandom_range(POOL_GROUPS - 1)];
        send_join(random_join(grp));
      end
    end
    calm_tx = 1'b0;
    calm_rx = 1'b0;
  endtask

  // Receiver holds off while joins keep coming, then the sender drains fully.
  task automatic test_backpressure();
    wait_idle();
    calm_tx = 1'b1;
    holdoff_req = 400;
    repeat (12) send_join(random_join(group_pool[$urandom_range(POOL_GROUPS - 1)]));
    calm_tx = 1'b0;
    wait_idle();
    repeat (20) send_join(random_join(group_pool[$urandom_range(POOL_GROUPS - 1)]));
  endtask

  // Fill every slot, then mix full-table misses with hits on known groups.
  task automatic test_table_full();
    int r;
    logic [127:0] grp;
    wait_idle();
    write_reg(CFG_SUBSCRIPTION_TIMEOUT, 32'd5);
    while (groups_in_use < TABLE_SLOTS)
      send_join(join_of(fresh_group(), $urandom_range(7), $urandom));
    repeat (120) begin
      r = $urandom_range(99);
      grp = group_pool[$urandom_range(POOL_GROUPS - 1)];
      if (r < 30) grp = fresh_group();
      else if (r < 40) grp = grp ^ (128'b1 << $urandom_range(127));
      send_join(random_join(grp));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_joins();
    test_register_settings();
    test_random_joins();
    test_backpressure();
    test_table_full();
    wait_idle();
    repeat (70) @(posedge clk);
    $display("Sent %0d joins, checked %0d replies: %0d groups allocated, %0d forwards,",
             joins_sent, replies_seen, groups_in_use, forwards);
    $display("%0d new memberships, %0d full-table replies, %0d register writes.",
             new_members, full_replies, reg_writes);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run guard, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
